// File: sv/mtm_pkg.sv
package mtm_pkg;

	// fixed widths of the group datapath
	localparam int SUM_W = 20;
	localparam int MED_W = 16;
	localparam int AVG_W = 16;
	localparam logic [AVG_W-1:0] AVG_MAX = 16'hFFFF;

	// configuration register widths
	localparam int WSIZE_W = 5;
	localparam int MIDX_W = 4;
	localparam int GSIZE_W = 5;
	localparam int SHIFT_W = 3;

	// configuration register reset values
	localparam logic [WSIZE_W-1:0] WSIZE_RESET = 5'd15;
	localparam logic [MIDX_W-1:0] MIDX_RESET = 4'd7;
	localparam logic [GSIZE_W-1:0] GSIZE_RESET = 5'd6;
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd2;

	// register map, byte address 4*index
	localparam int ADDR_W = 4;
	typedef enum logic [1:0] {
		REG_WINDOW_SIZE,
		REG_MEDIAN_INDEX,
		REG_GROUP_SIZE,
		REG_AVERAGE_SHIFT
	} reg_code_t;

	// median queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [MED_W-1:0]   median;
		logic [GSIZE_W-1:0] group_size;
		logic [SHIFT_W-1:0] shift;
	} med_word_t;

	// front sequencer states
	typedef enum logic [1:0] {
		FRONT_COLLECT,
		FRONT_SORT,
		FRONT_EMIT
	} front_state_t;

endpackage

// File: sv/mtm_front.sv
module mtm_front #(
	parameter int WINDOW_MAX = 16,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [SAMPLE_BITS-1:0]          sample,
	input  logic [mtm_pkg::WSIZE_W-1:0]     window_size,
	input  logic [mtm_pkg::MIDX_W-1:0]      median_index,
	input  logic [mtm_pkg::GSIZE_W-1:0]     group_size,
	input  logic [mtm_pkg::SHIFT_W-1:0]     average_shift,
	output logic                            q_push,
	input  logic                            q_full,
	output mtm_pkg::med_word_t              q_word
);

	localparam int NW = $clog2(WINDOW_MAX + 1);
	localparam int IW = $clog2(WINDOW_MAX);

	mtm_pkg::front_state_t state_q, state_nx;

	logic [SAMPLE_BITS-1:0] row_q [WINDOW_MAX];
	logic [SAMPLE_BITS-1:0] row_nx [WINDOW_MAX];
	logic [NW-1:0] fill_q;
	logic [NW-1:0] phase_q;
	logic [NW-1:0] n_q;
	logic [IW-1:0] pos_q;
	logic [mtm_pkg::GSIZE_W-1:0] grp_q;
	logic [mtm_pkg::SHIFT_W-1:0] shift_q;

	logic [NW-1:0] n_c;
	logic [IW-1:0] pos_c;
	logic accept;
	logic last;
	logic sort_done;

	// effective window length and median position
	always_comb begin
		if (window_size == '0) begin
			n_c = NW'(1);
		end else if (32'(window_size) > WINDOW_MAX) begin
			n_c = NW'(WINDOW_MAX);
		end else begin
			n_c = NW'(window_size);
		end
		if (32'(median_index) >= 32'(n_c)) begin
			pos_c = IW'(n_c - NW'(1));
		end else begin
			pos_c = IW'(median_index);
		end
	end

	assign full = (state_q != mtm_pkg::FRONT_COLLECT);
	assign accept = push && !full;
	assign last = ((NW+1)'(fill_q) + (NW+1)'(1)) >= (NW+1)'(n_c);
	assign sort_done = (phase_q == n_q - NW'(1));

	// one odd-even transposition phase over the first n_q cells
	always_comb begin
		row_nx = row_q;
		for (int k = 0; k < WINDOW_MAX - 1; k++) begin
			if (1'(k) == phase_q[0] && (k + 1) < int'(n_q)) begin
				if (row_q[k] > row_q[k+1]) begin
					row_nx[k] = row_q[k+1];
					row_nx[k+1] = row_q[k];
				end
			end
		end
	end

	// window cells
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q[fill_q[IW-1:0]] <= sample;
		end else if (state_q == mtm_pkg::FRONT_SORT) begin
			row_q <= row_nx;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtm_pkg::FRONT_COLLECT;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state and queue push
	always_comb begin
		state_nx = state_q;
		q_push = 1'b0;
		case (state_q)
			mtm_pkg::FRONT_COLLECT: begin
				if (accept && last) begin
					state_nx = mtm_pkg::FRONT_SORT;
				end
			end
			mtm_pkg::FRONT_SORT: begin
				if (sort_done) begin
					state_nx = mtm_pkg::FRONT_EMIT;
				end
			end
			mtm_pkg::FRONT_EMIT: begin
				if (!q_full) begin
					q_push = 1'b1;
					state_nx = mtm_pkg::FRONT_COLLECT;
				end
			end
			default: begin
				state_nx = mtm_pkg::FRONT_COLLECT;
			end
		endcase
	end

	// fill count, phase count and settings captured per window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			phase_q <= '0;
			n_q <= NW'(1);
			pos_q <= '0;
			grp_q <= '0;
			shift_q <= '0;
		end else begin
			if (accept) begin
				if (last) begin
					fill_q <= '0;
					phase_q <= '0;
					n_q <= n_c;
					pos_q <= pos_c;
					grp_q <= group_size;
					shift_q <= average_shift;
				end else begin
					fill_q <= fill_q + NW'(1);
				end
			end else if (state_q == mtm_pkg::FRONT_SORT) begin
				phase_q <= phase_q + NW'(1);
			end
		end
	end

	// median word toward the back
	always_comb begin
		q_word.median = mtm_pkg::MED_W'(row_q[pos_q]);
		q_word.group_size = grp_q;
		q_word.shift = shift_q;
	end

endmodule

// File: sv/mtm_queue.sv
module mtm_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  mtm_pkg::med_word_t wr_word,
	output logic               full,
	input  logic               rd_en,
	output mtm_pkg::med_word_t rd_word,
	output logic               empty
);

	localparam int PW = $clog2(mtm_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(mtm_pkg::QUEUE_DEPTH + 1);

	mtm_pkg::med_word_t slot_q [mtm_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CW'(mtm_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign rd_word = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_word;
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				if (wr_ptr_q == PW'(mtm_pkg::QUEUE_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + PW'(1);
				end
			end
			if (rd_en) begin
				if (rd_ptr_q == PW'(mtm_pkg::QUEUE_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + PW'(1);
				end
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: sv/mtm_back.sv
module mtm_back #(
	parameter int GROUP_MAX = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	input  mtm_pkg::med_word_t           q_word,
	output logic                         q_pop,
	output logic                         empty,
	input  logic                         pop,
	output logic [mtm_pkg::AVG_W-1:0]    average
);

	localparam int GW = $clog2(GROUP_MAX + 1);

	logic [mtm_pkg::SUM_W-1:0] sum_q;
	logic [mtm_pkg::MED_W-1:0] largest_q;
	logic [mtm_pkg::MED_W-1:0] smallest_q;
	logic [GW-1:0] gfill_q;
	logic finish_q;
	logic [mtm_pkg::SHIFT_W-1:0] shift_q;
	logic out_valid_q;
	logic [mtm_pkg::AVG_W-1:0] average_q;

	logic [GW-1:0] g_c;
	logic group_last;
	logic slot_free;
	logic [mtm_pkg::MED_W:0] trim_c;
	logic [mtm_pkg::SUM_W-1:0] diff_c;
	logic [mtm_pkg::SUM_W-1:0] shifted_c;
	logic [mtm_pkg::AVG_W-1:0] avg_c;

	// effective group length
	always_comb begin
		if (q_word.group_size == '0) begin
			g_c = GW'(1);
		end else if (32'(q_word.group_size) > GROUP_MAX) begin
			g_c = GW'(GROUP_MAX);
		end else begin
			g_c = GW'(q_word.group_size);
		end
	end

	assign q_pop = !q_empty && !finish_q;
	assign group_last = ((GW+1)'(gfill_q) + (GW+1)'(1)) >= (GW+1)'(g_c);
	assign slot_free = !out_valid_q || pop;
	assign empty = !out_valid_q;
	assign average = average_q;

	// trimmed sum, shifted and saturated
	always_comb begin
		trim_c = (mtm_pkg::MED_W+1)'(largest_q) + (mtm_pkg::MED_W+1)'(smallest_q);
		diff_c = sum_q - mtm_pkg::SUM_W'(trim_c);
		shifted_c = diff_c >> shift_q;
		if (sum_q < mtm_pkg::SUM_W'(trim_c)) begin
			avg_c = '0;
		end else if (shifted_c > mtm_pkg::SUM_W'(mtm_pkg::AVG_MAX)) begin
			avg_c = mtm_pkg::AVG_MAX;
		end else begin
			avg_c = mtm_pkg::AVG_W'(shifted_c);
		end
	end

	// group accumulation and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			largest_q <= '0;
			smallest_q <= mtm_pkg::AVG_MAX;
			gfill_q <= '0;
			finish_q <= 1'b0;
			shift_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				if (q_word.median > largest_q) begin
					largest_q <= q_word.median;
				end
				if (q_word.median < smallest_q) begin
					smallest_q <= q_word.median;
				end
				sum_q <= sum_q + mtm_pkg::SUM_W'(q_word.median);
				if (group_last) begin
					gfill_q <= '0;
					finish_q <= 1'b1;
					shift_q <= q_word.shift;
				end else begin
					gfill_q <= gfill_q + GW'(1);
				end
			end
			if (finish_q && slot_free) begin
				out_valid_q <= 1'b1;
				finish_q <= 1'b0;
				sum_q <= '0;
				largest_q <= '0;
				smallest_q <= mtm_pkg::AVG_MAX;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (finish_q && slot_free) begin
			average_q <= avg_c;
		end
	end

endmodule

// File: sv/median_trimmed_mean_filter_unit.sv
// path: a window is sorted, its median passes the median queue, and the back registers
// the group average; throughput: one sample per cycle while a window fills; the sample
// that completes a window holds full high while the window sorts (one odd-even sort phase
// per cycle) and until its median enters the queue; medians wait in a two-word queue and
// averages in one result register; reset: arst_n clears fill counts, sum and largest, sets
// smallest to all ones and the registers to defaults; window cells are not cleared
module median_trimmed_mean_filter_unit #(
	parameter int WINDOW_MAX = 16,
	parameter int GROUP_MAX = 16,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [SAMPLE_BITS-1:0]        sample,
	output logic                          empty,
	input  logic                          pop,
	output logic [mtm_pkg::AVG_W-1:0]     average,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mtm_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic [mtm_pkg::WSIZE_W-1:0] window_size_q;
	logic [mtm_pkg::MIDX_W-1:0] median_index_q;
	logic [mtm_pkg::GSIZE_W-1:0] group_size_q;
	logic [mtm_pkg::SHIFT_W-1:0] average_shift_q;

	logic cfg_wr;
	mtm_pkg::reg_code_t cfg_code;

	logic fq_push;
	logic fq_full;
	logic fq_pop;
	logic fq_empty;
	mtm_pkg::med_word_t fq_wr_word;
	mtm_pkg::med_word_t fq_rd_word;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign cfg_code = mtm_pkg::reg_code_t'(paddr[3:2]);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= mtm_pkg::WSIZE_RESET;
			median_index_q <= mtm_pkg::MIDX_RESET;
			group_size_q <= mtm_pkg::GSIZE_RESET;
			average_shift_q <= mtm_pkg::SHIFT_RESET;
		end else if (cfg_wr) begin
			case (cfg_code)
				mtm_pkg::REG_WINDOW_SIZE: window_size_q <= pwdata[mtm_pkg::WSIZE_W-1:0];
				mtm_pkg::REG_MEDIAN_INDEX: median_index_q <= pwdata[mtm_pkg::MIDX_W-1:0];
				mtm_pkg::REG_GROUP_SIZE: group_size_q <= pwdata[mtm_pkg::GSIZE_W-1:0];
				mtm_pkg::REG_AVERAGE_SHIFT: average_shift_q <= pwdata[mtm_pkg::SHIFT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// register readback
	always_comb begin
		case (cfg_code)
			mtm_pkg::REG_WINDOW_SIZE: prdata = 32'(window_size_q);
			mtm_pkg::REG_MEDIAN_INDEX: prdata = 32'(median_index_q);
			mtm_pkg::REG_GROUP_SIZE: prdata = 32'(group_size_q);
			mtm_pkg::REG_AVERAGE_SHIFT: prdata = 32'(average_shift_q);
			default: prdata = '0;
		endcase
	end

	// window collection, sort and median pick
	mtm_front #(
		.WINDOW_MAX(WINDOW_MAX),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.sample(sample),
		.window_size(window_size_q),
		.median_index(median_index_q),
		.group_size(group_size_q),
		.average_shift(average_shift_q),
		.q_push(fq_push),
		.q_full(fq_full),
		.q_word(fq_wr_word)
	);

	// median queue
	mtm_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(fq_push),
		.wr_word(fq_wr_word),
		.full(fq_full),
		.rd_en(fq_pop),
		.rd_word(fq_rd_word),
		.empty(fq_empty)
	);

	// group accumulation and olympic average
	mtm_back #(
		.GROUP_MAX(GROUP_MAX)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(fq_empty),
		.q_word(fq_rd_word),
		.q_pop(fq_pop),
		.empty(empty),
		.pop(pop),
		.average(average)
	);

endmodule

// File: tb/median_trimmed_mean_filter_unit_test.sv
`timescale 1ns / 1ps

module median_trimmed_mean_filter_unit_test;

	localparam int WIN_MAX = 16;
	localparam int GRP_MAX = 16;
	localparam int SMP_W = 12;
	localparam int SETTLE_CYCLES = 48;
	localparam int SAMPLE_GOAL = 1650;
	localparam int CYCLE_LIMIT = 2000000;
	localparam logic [mtm_pkg::MED_W-1:0] MED_NONE = '1;

	typedef enum logic [1:0] {
		ROW_SAMPLE,
		ROW_WRITE,
		ROW_READ
	} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		mtm_pkg::reg_code_t code;
		logic [31:0]        data;
		bit                 has_want;
		logic [31:0]        want;
	} step_t;

	localparam int PLAN_LEN = 40;

	// directed part: typed-in averages only where they are obvious
	step_t plan [PLAN_LEN] = '{
		// register defaults after reset
		'{ROW_READ, mtm_pkg::REG_WINDOW_SIZE, 32'd0, 1'b1, 32'd15},
		'{ROW_READ, mtm_pkg::REG_MEDIAN_INDEX, 32'd0, 1'b1, 32'd7},
		'{ROW_READ, mtm_pkg::REG_GROUP_SIZE, 32'd0, 1'b1, 32'd6},
		'{ROW_READ, mtm_pkg::REG_AVERAGE_SHIFT, 32'd0, 1'b1, 32'd2},
		// window of one, group of one: trim is at least the sum, average is zero
		'{ROW_WRITE, mtm_pkg::REG_WINDOW_SIZE, 32'd1, 1'b0, 32'd0},
		'{ROW_WRITE, mtm_pkg::REG_GROUP_SIZE, 32'd1, 1'b0, 32'd0},
		'{ROW_WRITE, mtm_pkg::REG_AVERAGE_SHIFT, 32'd0, 1'b0, 32'd0},
		'{ROW_SAMPLE, mtm_pkg::REG_WINDOW_SIZE, 32'd4095, 1'b1, 32'd0},
		'{ROW_SAMPLE, mtm_pkg::REG_WINDOW_SIZE, 32'd0, 1'b1, 32'd0},
		// three full-scale medians leave one full-scale sample
		'{ROW_WRITE, mtm_pkg::REG_GROUP_SIZE, 32'd3, 1'b0, 32'd0},
		'{ROW_SAMPLE, mtm_pkg::REG_WINDOW_SIZE, 32'd4095, 1'b0, 32'd0},
		'{ROW_SAMPLE, mtm_pkg::REG_WINDOW_SIZE, 32'd4095, 1'b0, 32'd0},
		'{ROW_SAMPLE, mtm_pkg::REG_WINDOW_SIZE, 32'd4095, 1'b1, 32'd4095},
		// zero sizes act as one
		'{ROW_WRITE, mtm_pkg::REG_WINDOW_SIZE, 32'd0, 1'b0, 32'd0},
		'{ROW_WRITE, mtm_pkg::REG_GROUP_SIZE, 32'd0, 1'b0, 32'd0},
		'{ROW_SAMPLE, mtm_pkg::REG_WINDOW_SIZE, 32'd123, 1'b1, 32'd0},
		// median index past the window clamps to the last position
		'{ROW_WRITE, mtm_pkg::REG_WINDOW_SIZE, 32'd3, 1'b0, 32'd0},
		'{ROW_WRITE, mtm_pkg::REG_MEDIAN_INDEX, 32'd15, 1'b0, 32'd0},
		'{ROW_WRITE, mtm_pkg::REG_GROUP_SIZE, 32'd3, 1'b0, 32'd0},
		'{ROW_WRITE, mtm_pkg::REG_AVERAGE_SHIFT, 32'd0, 1'b0, 32'd0},
		'{ROW_SAMPLE, mtm_pkg::REG_WINDOW_SIZE, 32'd7, 1'b0, 32'd0},
		'{ROW_SAMPLE, mtm_pkg::REG_WINDOW_SIZE, 32'd4095, 1'b0, 32'd0},
		'{ROW_SAMPLE, mtm_pkg::REG_WINDOW_SIZE, 32'd0, 1'b0, 32'd0},
		'{ROW_SAMPLE, mtm_pkg::REG_WINDOW_SIZE, 32'd100, 1'b0, 32'd0},
		'{ROW_SAMPLE, mtm_pkg::REG_WINDOW_SIZE, 32'd200, 1'b0, 32'd0},
		'{ROW_SAMPLE, mtm_pkg::REG_WINDOW_SIZE, 32'd300, 1'b0, 32'd0},
		'{ROW_SAMPLE, mtm_pkg::REG_WINDOW_SIZE, 32'd4095, 1'b0, 32'd0},
		'{ROW_SAMPLE, mtm_pkg::REG_WINDOW_SIZE, 32'd4095, 1'b0, 32'd0},
		'{ROW_SAMPLE, mtm_pkg::REG_WINDOW_SIZE, 32'd1, 1'b0, 32'd0},
		// widest shift, then the window shrinks below its fill
		'{ROW_WRITE, mtm_pkg::REG_MEDIAN_INDEX, 32'd0, 1'b0, 32'd0},
		'{ROW_WRITE, mtm_pkg::REG_WINDOW_SIZE, 32'd5, 1'b0, 32'd0},
		'{ROW_WRITE, mtm_pkg::REG_GROUP_SIZE, 32'd2, 1'b0, 32'd0},
		'{ROW_WRITE, mtm_pkg::REG_AVERAGE_SHIFT, 32'd7, 1'b0, 32'd0},
		'{ROW_SAMPLE, mtm_pkg::REG_WINDOW_SIZE, 32'd10, 1'b0, 32'd0},
		'{ROW_SAMPLE, mtm_pkg::REG_WINDOW_SIZE, 32'd20, 1'b0, 32'd0},
		'{ROW_SAMPLE, mtm_pkg::REG_WINDOW_SIZE, 32'd30, 1'b0, 32'd0},
		'{ROW_WRITE, mtm_pkg::REG_WINDOW_SIZE, 32'd2, 1'b0, 32'd0},
		'{ROW_SAMPLE, mtm_pkg::REG_WINDOW_SIZE, 32'd40, 1'b0, 32'd0},
		'{ROW_SAMPLE, mtm_pkg::REG_WINDOW_SIZE, 32'd50, 1'b0, 32'd0},
		'{ROW_SAMPLE, mtm_pkg::REG_WINDOW_SIZE, 32'd60, 1'b0, 32'd0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [SMP_W-1:0] sample = '0;
	logic empty;
	logic pop = 1'b0;
	logic [mtm_pkg::AVG_W-1:0] average;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [mtm_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// handshakes seen just before the coming rising edge
	bit push_taken;
	bit pop_taken;
	bit apb_done;
	logic [31:0] rd_word;

	// typed-in average that rides along with the sample word
	bit typed_on = 1'b0;
	logic [mtm_pkg::AVG_W-1:0] typed_avg = '0;

	// register copies and filter state of the predictor
	logic [31:0] reg_shadow [4];
	logic [SMP_W-1:0] win_cells [WIN_MAX];
	int win_fill = 0;
	logic [mtm_pkg::SUM_W-1:0] grp_sum = '0;
	int grp_fill = 0;
	logic [mtm_pkg::MED_W-1:0] top_med = '0;
	logic [mtm_pkg::MED_W-1:0] low_med = MED_NONE;

	logic [mtm_pkg::AVG_W-1:0] awaited_averages [$];
	int errors = 0;
	int samples_sent = 0;
	int cycles = 0;
	bit send_calm = 1'b0;
	bit pop_calm = 1'b0;
	int pop_hold = 0;

	median_trimmed_mean_filter_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.sample(sample),
		.empty(empty),
		.pop(pop),
		.average(average),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(12, 60);
		return $urandom_range(1, 3);
	endfunction

	// window and group sizes: mostly small, sometimes zero, full or past the top
	function automatic logic [31:0] size_pick();
		case ($urandom_range(0, 15))
			0: return 32'd0;
			1: return 32'd31;
			2: return 32'd16;
			3: return 32'($urandom_range(0, 31));
			default: return 32'($urandom_range(1, 5));
		endcase
	endfunction

	// one sample into the window; a finished group yields its trimmed average
	task automatic filter_sample(input logic [SMP_W-1:0] s, output bit done,
			output logic [mtm_pkg::AVG_W-1:0] avg);
		int n;
		int g;
		int pos;
		int trim;
		int rest;
		logic [SMP_W-1:0] t;
		logic [mtm_pkg::MED_W-1:0] med;
		n = int'(reg_shadow[mtm_pkg::REG_WINDOW_SIZE]);
		g = int'(reg_shadow[mtm_pkg::REG_GROUP_SIZE]);
		n = (n == 0) ? 1 : ((n > WIN_MAX) ? WIN_MAX : n);
		g = (g == 0) ? 1 : ((g > GRP_MAX) ? GRP_MAX : g);
		done = 1'b0;
		avg = '0;
		if (win_fill >= WIN_MAX)
			win_fill = 0;
		win_cells[win_fill] = s;
		win_fill++;
		if (win_fill < n)
			return;
		// in-place exchange sort of the first n cells
		for (int a = 0; a + 1 < n; a++) begin
			for (int b = a + 1; b < n; b++) begin
				if (win_cells[a] > win_cells[b]) begin
					t = win_cells[a];
					win_cells[a] = win_cells[b];
					win_cells[b] = t;
				end
			end
		end
		win_fill = 0;
		pos = (int'(reg_shadow[mtm_pkg::REG_MEDIAN_INDEX]) >= n) ? n - 1 :
			int'(reg_shadow[mtm_pkg::REG_MEDIAN_INDEX]);
		med = mtm_pkg::MED_W'(win_cells[pos]);
		if (med > top_med)
			top_med = med;
		if (med < low_med)
			low_med = med;
		grp_sum = grp_sum + mtm_pkg::SUM_W'(med);
		grp_fill++;
		if (grp_fill < g)
			return;
		// drop largest and smallest, then scale
		trim = int'(top_med) + int'(low_med);
		if (int'(grp_sum) >= trim)
			rest = (int'(grp_sum) - trim) >> reg_shadow[mtm_pkg::REG_AVERAGE_SHIFT];
		else
			rest = 0;
		if (rest > int'(mtm_pkg::AVG_MAX))
			rest = int'(mtm_pkg::AVG_MAX);
		avg = mtm_pkg::AVG_W'(rest);
		done = 1'b1;
		grp_sum = '0;
		grp_fill = 0;
		top_med = '0;
		low_med = MED_NONE;
	endtask

	// offer one sample word and hold it until taken
	task automatic send_sample(input logic [SMP_W-1:0] s, input bit has_want,
			input logic [mtm_pkg::AVG_W-1:0] want);
		int gap;
		gap = (send_calm || $urandom_range(0, 2) == 0) ? 0 : idle_len();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		sample <= s;
		typed_on <= has_want;
		typed_avg <= want;
		do @(posedge clk); while (!push_taken);
		samples_sent++;
		if ($urandom_range(0, 49) == 0)
			send_calm = !send_calm;
	endtask

	// stop sending, drain every awaited average, let a last sort finish
	task automatic settle();
		push <= 1'b0;
		while (awaited_averages.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input mtm_pkg::reg_code_t code, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {code, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!apb_done);
		psel <= 1'b0;
		penable <= 1'b0;
		case (code)
			mtm_pkg::REG_WINDOW_SIZE:
				reg_shadow[code] = v & ((32'd1 << mtm_pkg::WSIZE_W) - 1);
			mtm_pkg::REG_MEDIAN_INDEX:
				reg_shadow[code] = v & ((32'd1 << mtm_pkg::MIDX_W) - 1);
			mtm_pkg::REG_GROUP_SIZE:
				reg_shadow[code] = v & ((32'd1 << mtm_pkg::GSIZE_W) - 1);
			mtm_pkg::REG_AVERAGE_SHIFT:
				reg_shadow[code] = v & ((32'd1 << mtm_pkg::SHIFT_W) - 1);
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic check_read(input mtm_pkg::reg_code_t code, input logic [31:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {code, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!apb_done);
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd_word !== want) begin
			$display("%0t: register %s read expected %0d got %0d", $time, code.name(),
				want, rd_word);
			errors++;
		end
		@(posedge clk);
	endtask

	// outputs are stable at the falling edge; what is seen here is taken at the next rise
	always @(negedge clk) begin : watch
		bit done;
		logic [mtm_pkg::AVG_W-1:0] avg;
		logic [mtm_pkg::AVG_W-1:0] want;
		push_taken = arst_n && push && !full;
		pop_taken = arst_n && pop && !empty;
		apb_done = psel && penable && pready;
		if (apb_done)
			rd_word = prdata;
		if (push_taken) begin
			filter_sample(sample, done, avg);
			if (done)
				awaited_averages.push_back(typed_on ? typed_avg : avg);
		end
		if (pop_taken) begin
			if (awaited_averages.size() == 0) begin
				$display("%0t: average expected none got %0d", $time, average);
				errors++;
			end else begin
				want = awaited_averages.pop_front();
				if (average !== want) begin
					$display("%0t: average expected %0d got %0d", $time, want, average);
					errors++;
				end
			end
		end
	end

	// receiver with random stalls and calm stretches
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (pop_hold > 0) begin
			pop <= 1'b0;
			pop_hold--;
		end else begin
			pop <= 1'b1;
			if (!pop_calm && $urandom_range(0, 3) == 0)
				pop_hold = idle_len();
		end
		if ($urandom_range(0, 199) == 0)
			pop_calm = !pop_calm;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("** median_trimmed_mean_filter_unit: FAILED **");
			$finish;
		end
	end

	initial begin : stimulus
		mtm_pkg::reg_code_t code;
		logic [SMP_W-1:0] s;
		int burst;
		reg_shadow[mtm_pkg::REG_WINDOW_SIZE] = 32'(mtm_pkg::WSIZE_RESET);
		reg_shadow[mtm_pkg::REG_MEDIAN_INDEX] = 32'(mtm_pkg::MIDX_RESET);
		reg_shadow[mtm_pkg::REG_GROUP_SIZE] = 32'(mtm_pkg::GSIZE_RESET);
		reg_shadow[mtm_pkg::REG_AVERAGE_SHIFT] = 32'(mtm_pkg::SHIFT_RESET);
		for (int k = 0; k < WIN_MAX; k++)
			win_cells[k] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < PLAN_LEN; i++) begin
			case (plan[i].kind)
				ROW_WRITE: begin
					settle();
					reg_write(plan[i].code, plan[i].data);
				end
				ROW_READ: begin
					settle();
					check_read(plan[i].code, plan[i].want);
				end
				default: begin
					send_sample(plan[i].data[SMP_W-1:0], plan[i].has_want,
						plan[i].want[mtm_pkg::AVG_W-1:0]);
				end
			endcase
		end

		// random phases: new settings while drained, then a burst of samples
		while (samples_sent < SAMPLE_GOAL) begin
			settle();
			if ($urandom_range(0, 1) == 0)
				reg_write(mtm_pkg::REG_WINDOW_SIZE, size_pick());
			if ($urandom_range(0, 2) == 0)
				reg_write(mtm_pkg::REG_MEDIAN_INDEX, 32'($urandom_range(0, 15)));
			if ($urandom_range(0, 1) == 0)
				reg_write(mtm_pkg::REG_GROUP_SIZE, size_pick());
			if ($urandom_range(0, 2) == 0)
				reg_write(mtm_pkg::REG_AVERAGE_SHIFT, 32'($urandom_range(0, 7)));
			code = mtm_pkg::reg_code_t'($urandom_range(0, 3));
			check_read(code, reg_shadow[code]);
			burst = $urandom_range(4, 60);
			repeat (burst) begin
				if ($urandom_range(0, 7) == 0)
					s = ($urandom_range(0, 1) == 0) ? '1 : '0;
				else
					s = SMP_W'($urandom_range(0, 4095));
				send_sample(s, 1'b0, '0);
			end
		end

		settle();
		if (errors == 0)
			$display("** median_trimmed_mean_filter_unit: PASSED **");
		else
			$display("** median_trimmed_mean_filter_unit: FAILED **");
		$finish;
	end

endmodule
